>>> rtl/byte_range_header_parser_core_assert.svh
// Assertion macros shared by the byte range header parser modules.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef BYTE_RANGE_HEADER_PARSER_CORE_ASSERT_SVH
`define BYTE_RANGE_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define BRHP_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held
`define BRHP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/brhp_pkg.sv
// Types, character constants and helper functions for the byte range header parser.
// No dependencies; imported by every module of the block.
package brhp_pkg;

    localparam int OFFSET_BITS    = 48;
    localparam int COUNT_OUT_BITS = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;

    localparam logic [2:0] UNIT_LEN = 3'd5;

    typedef enum logic [2:0] {
        UP_LEAD,
        UP_MATCH,
        UP_TRAIL,
        UP_BADUNIT,
        UP_SPECS,
        UP_IGNORE
    } unit_phase_t;

    typedef enum logic [2:0] {
        SP_START_WS,
        SP_START_SIGN,
        SP_START_DIG,
        SP_START_SKIP,
        SP_END_WS,
        SP_END_SIGN,
        SP_END_DIG,
        SP_END_SKIP
    } spec_phase_t;

    typedef enum logic [1:0] {
        CLS_NONE,
        CLS_MALFORMED,
        CLS_PARSED
    } spec_cls_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_MALFORMED,
        ST_UNSAT,
        ST_NONE
    } spec_status_t;

    typedef enum logic [1:0] {
        VD_FULL,
        VD_SINGLE,
        VD_MULTI,
        VD_UNSAT
    } verdict_t;

    typedef struct packed {
        logic nonblank;
        logic has_start;
        logic has_end;
        logic end_neg;
        logic bad;
    } spec_flags_t;

    // Control part of one closed spec, front to back
    typedef struct packed {
        spec_cls_t cls;
        logic      fin;
        logic      has_start;
        logic      has_end;
        logic      end_neg;
    } spec_ctl_t;

    // Characters of the unit name "bytes"
    function automatic logic [7:0] unit_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h62;
            3'd1:    ch = 8'h79;
            3'd2:    ch = 8'h74;
            3'd3:    ch = 8'h65;
            3'd4:    ch = 8'h73;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return c inside {CH_SPACE, [CH_TAB:CH_CR]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

endpackage

>>> rtl/byte_range_header_parser_core.sv
// The result of a byte that closes a spec (a comma or the final byte) is registered in a queue
// entry, then in the output register once that register is free, which sets output valid.
// Throughput: one header byte per cycle; the input stalls only while both queue entries hold
// closed specs behind a result that the result side has not taken.
// Reset clears the parser, the counters, the queue, output valid and resource_size to 0.
// Top level of the byte range header parser; depends on brhp_pkg, front, queue and back.
module byte_range_header_parser_core import brhp_pkg::*; #(
    parameter int VALUE_BITS = 48,
    parameter int COUNT_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [OFFSET_BITS-1:0]    cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_header_byte,
    input  logic                      s_is_final_byte,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_spec_status,
    output logic [OFFSET_BITS-1:0]    m_first_offset,
    output logic [OFFSET_BITS-1:0]    m_last_offset,
    output logic                      m_header_done,
    output logic [1:0]                m_header_verdict,
    output logic [COUNT_OUT_BITS-1:0] m_satisfiable_count
);

    localparam int REC_BITS = $bits(spec_ctl_t) + 2 * VALUE_BITS;

    logic                  in_fire;
    logic                  rec_push;
    spec_ctl_t             rec_ctl;
    logic [VALUE_BITS-1:0] rec_start;
    logic [VALUE_BITS-1:0] rec_end;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_valid;
    logic [REC_BITS-1:0]   q_data;
    spec_ctl_t             q_ctl;
    logic [VALUE_BITS-1:0] q_start;
    logic [VALUE_BITS-1:0] q_end;

    // Accept a byte whenever the queue has room
    assign s_ready = !q_full;
    assign in_fire = s_valid && s_ready;

    brhp_front #(
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .in_byte   (s_header_byte),
        .in_final  (s_is_final_byte),
        .rec_push  (rec_push),
        .rec_ctl   (rec_ctl),
        .rec_start (rec_start),
        .rec_end   (rec_end)
    );

    brhp_queue #(
        .WIDTH (REC_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data ({rec_ctl, rec_start, rec_end}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .not_empty (q_valid)
    );

    assign {q_ctl, q_start, q_end} = q_data;

    brhp_back #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .q_valid             (q_valid),
        .q_ctl               (q_ctl),
        .q_start             (q_start),
        .q_end               (q_end),
        .q_pop               (q_pop),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_spec_status       (m_spec_status),
        .m_first_offset      (m_first_offset),
        .m_last_offset       (m_last_offset),
        .m_header_done       (m_header_done),
        .m_header_verdict    (m_header_verdict),
        .m_satisfiable_count (m_satisfiable_count)
    );

endmodule

>>> rtl/brhp_queue.sv
// Short queue that decouples the parser front from the resolver back.
// Depends on brhp_pkg for the queue depth.
`include "byte_range_header_parser_core_assert.svh"

module brhp_queue import brhp_pkg::*; #(
    parameter int WIDTH = 104
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             not_empty
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]    data_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = data_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed request
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

    `BRHP_ASSERT_IMPL(a_no_overflow, push, !full, "push into a full queue")
    `BRHP_ASSERT_IMPL(a_no_underflow, pop, not_empty, "pop from an empty queue")

endmodule

>>> rtl/brhp_front.sv
// Parser front: takes header bytes, tracks unit and spec syntax, closes specs.
// Depends on brhp_pkg for phase types, character constants and the spec record.
`include "byte_range_header_parser_core_assert.svh"

module brhp_front import brhp_pkg::*; #(
    parameter int VALUE_BITS = 48
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic [7:0]            in_byte,
    input  logic                  in_final,
    output logic                  rec_push,
    output spec_ctl_t             rec_ctl,
    output logic [VALUE_BITS-1:0] rec_start,
    output logic [VALUE_BITS-1:0] rec_end
);

    unit_phase_t           unit_phase_reg, unit_phase_next;
    logic [2:0]            unit_idx_reg, unit_idx_next;
    spec_phase_t           spec_phase_reg, spec_phase_next;
    spec_flags_t           flags_reg, flags_next;
    logic [VALUE_BITS-1:0] start_reg, start_next;
    logic [VALUE_BITS-1:0] end_reg, end_next;

    // Spec state after feeding the current byte
    spec_phase_t           fed_phase;
    spec_flags_t           fed_flags;
    logic [VALUE_BITS-1:0] fed_start;
    logic [VALUE_BITS-1:0] fed_end;

    logic c_ws;
    logic c_dig;
    logic c_eq;
    logic c_comma;

    // Multiply by ten and add one digit, saturating at all ones
    function automatic logic [VALUE_BITS-1:0] acc_digit(
        input logic [VALUE_BITS-1:0] v,
        input logic [7:0]            c
    );
        logic [VALUE_BITS+3:0] wide;
        wide = ({4'b0000, v} << 3) + ({4'b0000, v} << 1)
             + {{VALUE_BITS{1'b0}}, c[3:0]};
        if (|wide[VALUE_BITS+3:VALUE_BITS]) begin
            return '1;
        end
        return wide[VALUE_BITS-1:0];
    endfunction

    function automatic spec_cls_t classify(
        input spec_phase_t p,
        input spec_flags_t f,
        input logic        by_end
    );
        spec_cls_t cls;
        if (!f.nonblank) begin
            cls = by_end ? CLS_NONE : CLS_MALFORMED;
        end else if (p < SP_END_WS || p == SP_END_SIGN || f.bad ||
                     !(f.has_start || f.has_end)) begin
            cls = CLS_MALFORMED;
        end else begin
            cls = CLS_PARSED;
        end
        return cls;
    endfunction

    assign c_ws    = is_ws(in_byte);
    assign c_dig   = is_digit(in_byte);
    assign c_eq    = (in_byte == CH_EQUALS);
    assign c_comma = (in_byte == CH_COMMA);

    // Feed one byte into the spec scanner
    always_comb begin
        fed_phase = spec_phase_reg;
        fed_flags = flags_reg;
        fed_start = start_reg;
        fed_end   = end_reg;
        if (!c_ws) begin
            fed_flags.nonblank = 1'b1;
        end
        case (spec_phase_reg)
            SP_START_WS: begin
                if (!c_ws) begin
                    if (in_byte == CH_DASH) begin
                        fed_phase = SP_END_WS;
                    end else if (in_byte == CH_PLUS) begin
                        fed_phase = SP_START_SIGN;
                    end else if (c_dig) begin
                        fed_flags.has_start = 1'b1;
                        fed_start = acc_digit('0, in_byte);
                        fed_phase = SP_START_DIG;
                    end else begin
                        fed_flags.bad = 1'b1;
                        fed_phase = SP_START_SKIP;
                    end
                end
            end
            SP_START_SIGN: begin
                if (c_dig) begin
                    fed_flags.has_start = 1'b1;
                    fed_start = acc_digit('0, in_byte);
                    fed_phase = SP_START_DIG;
                end else begin
                    fed_flags.bad = 1'b1;
                    fed_phase = (in_byte == CH_DASH) ? SP_END_WS : SP_START_SKIP;
                end
            end
            SP_START_DIG: begin
                if (c_dig) begin
                    fed_start = acc_digit(start_reg, in_byte);
                end else begin
                    fed_phase = (in_byte == CH_DASH) ? SP_END_WS : SP_START_SKIP;
                end
            end
            SP_START_SKIP: begin
                if (in_byte == CH_DASH) begin
                    fed_phase = SP_END_WS;
                end
            end
            SP_END_WS: begin
                if (!c_ws) begin
                    if (in_byte == CH_PLUS) begin
                        fed_phase = SP_END_SIGN;
                    end else if (in_byte == CH_DASH) begin
                        fed_flags.end_neg = 1'b1;
                        fed_phase = SP_END_SIGN;
                    end else if (c_dig) begin
                        fed_flags.has_end = 1'b1;
                        fed_end = acc_digit('0, in_byte);
                        fed_phase = SP_END_DIG;
                    end else begin
                        fed_flags.bad = 1'b1;
                        fed_phase = SP_END_SKIP;
                    end
                end
            end
            SP_END_SIGN: begin
                if (c_dig) begin
                    fed_flags.has_end = 1'b1;
                    fed_end = acc_digit('0, in_byte);
                    fed_phase = SP_END_DIG;
                end else begin
                    fed_flags.bad = 1'b1;
                    fed_phase = SP_END_SKIP;
                end
            end
            SP_END_DIG: begin
                if (c_dig) begin
                    fed_end = acc_digit(end_reg, in_byte);
                end else begin
                    fed_phase = SP_END_SKIP;
                end
            end
            default: begin
                fed_phase = SP_END_SKIP;
            end
        endcase
    end

    // Next state and spec record
    always_comb begin
        unit_phase_next = unit_phase_reg;
        unit_idx_next   = unit_idx_reg;
        spec_phase_next = spec_phase_reg;
        flags_next      = flags_reg;
        start_next      = start_reg;
        end_next        = end_reg;

        rec_push          = 1'b0;
        rec_ctl.cls       = CLS_NONE;
        rec_ctl.fin       = in_final;
        rec_ctl.has_start = 1'b0;
        rec_ctl.has_end   = 1'b0;
        rec_ctl.end_neg   = 1'b0;
        rec_start         = '0;
        rec_end           = '0;

        if (in_fire) begin
            if (unit_phase_reg == UP_SPECS) begin
                if (c_comma) begin
                    // Close the spec as it stands, then clear it
                    rec_push          = 1'b1;
                    rec_ctl.cls       = classify(spec_phase_reg, flags_reg, 1'b0);
                    rec_ctl.has_start = flags_reg.has_start;
                    rec_ctl.has_end   = flags_reg.has_end;
                    rec_ctl.end_neg   = flags_reg.end_neg;
                    rec_start         = start_reg;
                    rec_end           = end_reg;
                    spec_phase_next   = SP_START_WS;
                    flags_next        = '0;
                    start_next        = '0;
                    end_next          = '0;
                end else begin
                    spec_phase_next = fed_phase;
                    flags_next      = fed_flags;
                    start_next      = fed_start;
                    end_next        = fed_end;
                    if (in_final) begin
                        rec_ctl.cls       = classify(fed_phase, fed_flags, 1'b1);
                        rec_ctl.has_start = fed_flags.has_start;
                        rec_ctl.has_end   = fed_flags.has_end;
                        rec_ctl.end_neg   = fed_flags.end_neg;
                        rec_start         = fed_start;
                        rec_end           = fed_end;
                    end
                end
            end else if (unit_phase_reg != UP_IGNORE) begin
                // Match the unit name before the first equals sign
                case (unit_phase_reg)
                    UP_LEAD: begin
                        if (!c_ws) begin
                            if (c_eq) begin
                                unit_phase_next = UP_IGNORE;
                            end else if (in_byte == unit_char(3'd0)) begin
                                unit_idx_next   = 3'd1;
                                unit_phase_next = UP_MATCH;
                            end else begin
                                unit_phase_next = UP_BADUNIT;
                            end
                        end
                    end
                    UP_MATCH: begin
                        if (c_eq) begin
                            unit_phase_next = (unit_idx_reg == UNIT_LEN) ? UP_SPECS : UP_IGNORE;
                        end else if (c_ws) begin
                            unit_phase_next = (unit_idx_reg == UNIT_LEN) ? UP_TRAIL : UP_BADUNIT;
                        end else if (unit_idx_reg < UNIT_LEN &&
                                     in_byte == unit_char(unit_idx_reg)) begin
                            unit_idx_next = unit_idx_reg + 3'd1;
                        end else begin
                            unit_phase_next = UP_BADUNIT;
                        end
                    end
                    UP_TRAIL: begin
                        if (c_eq) begin
                            unit_phase_next = UP_SPECS;
                        end else if (!c_ws) begin
                            unit_phase_next = UP_BADUNIT;
                        end
                    end
                    UP_BADUNIT: begin
                        if (c_eq) begin
                            unit_phase_next = UP_IGNORE;
                        end
                    end
                    default: begin
                        unit_phase_next = UP_IGNORE;
                    end
                endcase
            end

            // The final byte always closes the header and drops all state
            if (in_final) begin
                rec_push        = 1'b1;
                unit_phase_next = UP_LEAD;
                unit_idx_next   = 3'd0;
                spec_phase_next = SP_START_WS;
                flags_next      = '0;
                start_next      = '0;
                end_next        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            unit_phase_reg <= UP_LEAD;
            unit_idx_reg   <= 3'd0;
            spec_phase_reg <= SP_START_WS;
            flags_reg      <= '0;
            start_reg      <= '0;
            end_reg        <= '0;
        end else begin
            unit_phase_reg <= unit_phase_next;
            unit_idx_reg   <= unit_idx_next;
            spec_phase_reg <= spec_phase_next;
            flags_reg      <= flags_next;
            start_reg      <= start_next;
            end_reg        <= end_next;
        end
    end

    `BRHP_ASSERT_NEXT(a_final_clears, in_fire && in_final, unit_phase_reg == UP_LEAD && spec_phase_reg == SP_START_WS && flags_reg == '0, "parser not back at start after final byte")

endmodule

>>> rtl/brhp_back.sv
// Resolver back: checks each closed spec against the resource size, counts, and
// holds the result in an output register. Depends on brhp_pkg.
`include "byte_range_header_parser_core_assert.svh"

module brhp_back import brhp_pkg::*; #(
    parameter int VALUE_BITS = 48,
    parameter int COUNT_BITS = 16
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [OFFSET_BITS-1:0]    cfg_wr_data,
    input  logic                      q_valid,
    input  spec_ctl_t                 q_ctl,
    input  logic [VALUE_BITS-1:0]     q_start,
    input  logic [VALUE_BITS-1:0]     q_end,
    output logic                      q_pop,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [1:0]                m_spec_status,
    output logic [OFFSET_BITS-1:0]    m_first_offset,
    output logic [OFFSET_BITS-1:0]    m_last_offset,
    output logic                      m_header_done,
    output logic [1:0]                m_header_verdict,
    output logic [COUNT_OUT_BITS-1:0] m_satisfiable_count
);

    localparam int CMP_BITS = (VALUE_BITS > OFFSET_BITS) ? VALUE_BITS : OFFSET_BITS;

    logic [OFFSET_BITS-1:0] size_reg;
    logic [COUNT_BITS-1:0]  parsed_reg, parsed_next;
    logic [COUNT_BITS-1:0]  sat_reg, sat_next;
    logic [COUNT_BITS-1:0]  parsed_upd;
    logic [COUNT_BITS-1:0]  sat_upd;

    logic                   valid_reg, valid_next;
    spec_status_t           status_reg;
    logic [OFFSET_BITS-1:0] first_reg;
    logic [OFFSET_BITS-1:0] last_reg;
    logic                   done_reg;
    verdict_t               verdict_reg;
    logic [COUNT_BITS-1:0]  count_reg;

    logic [CMP_BITS-1:0] total_w;
    logic [CMP_BITS-1:0] start_w;
    logic [CMP_BITS-1:0] end_w;
    logic                end_neg;
    spec_status_t        res_status;
    logic [CMP_BITS-1:0] res_first;
    logic [CMP_BITS-1:0] res_last;
    spec_status_t        status;
    logic [CMP_BITS-1:0] out_first;
    logic [CMP_BITS-1:0] out_last;
    verdict_t            verdict;

    assign total_w = CMP_BITS'(size_reg);
    assign start_w = CMP_BITS'(q_start);
    assign end_w   = CMP_BITS'(q_end);
    assign end_neg = q_ctl.end_neg && (q_end != '0);

    // Resolve the spec as suffix, open or clamped range
    always_comb begin
        res_status = ST_OK;
        res_first  = '0;
        res_last   = '0;
        if (total_w == '0) begin
            res_status = ST_UNSAT;
        end else if (!q_ctl.has_start) begin
            if (end_neg || end_w == '0) begin
                res_status = ST_UNSAT;
            end else begin
                res_first = (end_w >= total_w) ? '0 : total_w - end_w;
                res_last  = total_w - 1'b1;
            end
        end else if (start_w >= total_w) begin
            res_status = ST_UNSAT;
        end else begin
            res_first = start_w;
            if (!q_ctl.has_end) begin
                res_last = total_w - 1'b1;
            end else if (end_neg || end_w < start_w) begin
                res_status = ST_UNSAT;
            end else begin
                res_last = (end_w >= total_w) ? total_w - 1'b1 : end_w;
            end
        end
    end

    // Pick the status, update the counters and form the verdict
    always_comb begin
        case (q_ctl.cls)
            CLS_NONE:      status = ST_NONE;
            CLS_MALFORMED: status = ST_MALFORMED;
            default:       status = res_status;
        endcase
        out_first = (status == ST_OK) ? res_first : '0;
        out_last  = (status == ST_OK) ? res_last : '0;

        parsed_upd = parsed_reg;
        if (q_ctl.cls == CLS_PARSED && parsed_reg != '1) begin
            parsed_upd = parsed_reg + 1'b1;
        end
        sat_upd = sat_reg;
        if (status == ST_OK && sat_reg != '1) begin
            sat_upd = sat_reg + 1'b1;
        end

        verdict = VD_FULL;
        if (q_ctl.fin) begin
            if (parsed_upd == '0) begin
                verdict = VD_FULL;
            end else if (sat_upd == '0) begin
                verdict = VD_UNSAT;
            end else if (sat_upd == COUNT_BITS'(1)) begin
                verdict = VD_SINGLE;
            end else begin
                verdict = VD_MULTI;
            end
        end

        q_pop       = q_valid && (!valid_reg || m_ready);
        parsed_next = parsed_reg;
        sat_next    = sat_reg;
        valid_next  = valid_reg && !m_ready;
        if (q_pop) begin
            parsed_next = q_ctl.fin ? '0 : parsed_upd;
            sat_next    = q_ctl.fin ? '0 : sat_upd;
            valid_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= '0;
            parsed_reg <= '0;
            sat_reg    <= '0;
            valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            parsed_reg <= parsed_next;
            sat_reg    <= sat_next;
            valid_reg  <= valid_next;
        end
    end

    // Load the output register when a request is popped
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            status_reg  <= status;
            first_reg   <= OFFSET_BITS'(out_first);
            last_reg    <= OFFSET_BITS'(out_last);
            done_reg    <= q_ctl.fin;
            verdict_reg <= verdict;
            count_reg   <= sat_upd;
        end
    end

    assign m_valid             = valid_reg;
    assign m_spec_status       = status_reg;
    assign m_first_offset      = first_reg;
    assign m_last_offset       = last_reg;
    assign m_header_done       = done_reg;
    assign m_header_verdict    = verdict_reg;
    assign m_satisfiable_count = COUNT_OUT_BITS'(count_reg);

    `BRHP_ASSERT_IMPL(a_range_ordered, valid_reg && status_reg == ST_OK, first_reg <= last_reg, "satisfiable range has first above last")
    `BRHP_ASSERT_IMPL(a_dropped_zero, valid_reg && status_reg != ST_OK, first_reg == '0 && last_reg == '0, "offsets not zero on a dropped spec")
    `BRHP_ASSERT_IMPL(a_verdict_only_done, valid_reg && !done_reg, verdict_reg == VD_FULL, "verdict set on a result that does not end the header")

endmodule
